[design/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the strict priority queue unit
// Class counts, pointer widths, command and result beats, cell control.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int PRIO_LEVELS  = 3;
    localparam int NUM_CLASSES  = PRIO_LEVELS + 1;

    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int CLS_W        = $clog2(NUM_CLASSES);
    localparam int ADDR_W       = CLS_W + PTR_W;
    localparam int STORE_DEPTH  = NUM_CLASSES * (2 ** PTR_W);

    localparam int TAG_W        = 16;
    localparam int SEV_W        = 3;
    localparam int LVL_W        = 2;

    typedef enum logic [1:0] {
        ACT_ADD_PLAIN = 2'd0,
        ACT_ADD_PRIO  = 2'd1,
        ACT_SERVE     = 2'd2,
        ACT_NOP       = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    typedef struct packed {
        t_action           action;
        logic [TAG_W-1:0]  tag_in;
        logic [SEV_W-1:0]  severity_in;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [TAG_W-1:0]  served_tag;
        logic              served_class;
        logic [LVL_W-1:0]  served_level;
    } t_res;

    // control into one class cell
    typedef struct packed {
        logic enq;
        logic serve;
    } t_cell_ctl;

    // status out of one class cell
    typedef struct packed {
        logic              full;
        logic              take;
        logic [PTR_W-1:0]  head;
        logic [PTR_W-1:0]  tail;
    } t_cell_sts;

    function automatic logic [CLS_W-1:0] clamp_level(input logic [SEV_W-1:0] sev);
        logic [CLS_W-1:0] lvl;
        if (sev == '0) begin
            lvl = CLS_W'(1);
        end else if (int'(sev) > PRIO_LEVELS) begin
            lvl = CLS_W'(PRIO_LEVELS);
        end else begin
            lvl = CLS_W'(sev);
        end
        return lvl;
    endfunction

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

endpackage

[design/spq_ram.sv]
// ----------------------------------------------------------------------------
// spq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one class of the queue chain
// Holds head, tail and fill count of one FIFO class and passes the serve
// claim down to the next lower class.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  spq_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_claim,
    output logic                  o_claim,
    output spq_pkg::t_cell_sts    o_sts
);

    logic [spq_pkg::PTR_W-1:0] r_head, n_head;
    logic [spq_pkg::PTR_W-1:0] r_tail, n_tail;
    logic [spq_pkg::CNT_W-1:0] r_cnt,  n_cnt;
    logic                      w_nonempty;
    logic                      w_take;

    assign w_nonempty = (r_cnt != '0);
    // a higher class that holds entries wins the serve
    assign w_take     = i_ctl.serve && !i_claim && w_nonempty;
    assign o_claim    = i_claim || w_nonempty;

    assign o_sts.full = (r_cnt == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
    assign o_sts.take = w_take;
    assign o_sts.head = r_head;
    assign o_sts.tail = r_tail;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_cnt  = r_cnt;
        if (i_ctl.enq) begin
            n_tail = spq_pkg::next_slot(r_tail);
            n_cnt  = r_cnt + spq_pkg::CNT_W'(1);
        end else if (w_take) begin
            n_head = spq_pkg::next_slot(r_head);
            n_cnt  = r_cnt - spq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

endmodule

[design/strict_priority_multi_queue_unit.sv]
// ----------------------------------------------------------------------------
// strict_priority_multi_queue_unit: strict priority multi-queue scheduler
// One plain FIFO class and one FIFO class per severity level; serve takes the
// oldest tag of the highest non-empty level, then the oldest plain tag.
// ----------------------------------------------------------------------------
// Each command has an execute cycle, in which the shared tag store is
// read or written once while the class cells update their pointers, then
// a result cycle in which o_strobe is high for exactly that cycle and a
// new command can already be started. busy is high only in the execute
// cycle. Results cannot be stalled; the receiver must take each beat in
// the cycle it is shown.
module strict_priority_multi_queue_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  spq_pkg::t_cmd   i_cmd,
    output logic            o_strobe,
    output spq_pkg::t_res   o_res
);

    spq_pkg::t_state  r_state, n_state;

    spq_pkg::t_action               r_action;
    logic [spq_pkg::CLS_W-1:0]      r_cls;
    logic [spq_pkg::TAG_W-1:0]      r_tag;

    spq_pkg::t_status               r_status;
    logic                           r_served_class;
    logic [spq_pkg::LVL_W-1:0]      r_served_level;

    spq_pkg::t_cell_ctl             w_ctl   [spq_pkg::NUM_CLASSES];
    spq_pkg::t_cell_sts             w_sts   [spq_pkg::NUM_CLASSES];
    logic [spq_pkg::NUM_CLASSES:0]  w_claim;

    logic                           w_accept;
    logic                           w_exec;
    logic                           w_is_enq;
    logic                           w_is_serve;
    logic                           w_target_full;
    logic [spq_pkg::PTR_W-1:0]      w_target_tail;
    logic                           w_enq_ok;
    logic                           w_any_take;
    logic [spq_pkg::CLS_W-1:0]      w_sel_cls;
    logic [spq_pkg::PTR_W-1:0]      w_sel_head;

    logic                           w_we;
    logic                           w_re;
    logic [spq_pkg::ADDR_W-1:0]     w_waddr;
    logic [spq_pkg::ADDR_W-1:0]     w_raddr;
    logic [spq_pkg::TAG_W-1:0]      w_rdata;

    // ---------------- control FSM ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        busy     = 1'b0;
        o_strobe = 1'b0;
        w_exec   = 1'b0;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (start) begin
                    n_state = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC: begin
                busy    = 1'b1;
                w_exec  = 1'b1;
                n_state = spq_pkg::S_RESP;
            end
            spq_pkg::S_RESP: begin
                o_strobe = 1'b1;
                n_state  = start ? spq_pkg::S_EXEC : spq_pkg::S_IDLE;
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    assign w_accept = start && !busy;

    // ---------------- command capture ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_cmd.action;
            r_tag    <= i_cmd.tag_in;
            if (i_cmd.action == spq_pkg::ACT_ADD_PRIO) begin
                r_cls <= spq_pkg::clamp_level(i_cmd.severity_in);
            end else begin
                r_cls <= '0;
            end
        end
    end

    // ---------------- class cell chain ----------------
    assign w_is_enq   = (r_action == spq_pkg::ACT_ADD_PLAIN) ||
                        (r_action == spq_pkg::ACT_ADD_PRIO);
    assign w_is_serve = (r_action == spq_pkg::ACT_SERVE);

    always_comb begin
        w_target_full = 1'b0;
        w_target_tail = '0;
        for (int k = 0; k < spq_pkg::NUM_CLASSES; k++) begin
            if (r_cls == spq_pkg::CLS_W'(k)) begin
                w_target_full = w_sts[k].full;
                w_target_tail = w_sts[k].tail;
            end
        end
    end

    assign w_enq_ok = w_exec && w_is_enq && !w_target_full;

    // claim enters at the highest level and ripples down to the plain class
    assign w_claim[spq_pkg::NUM_CLASSES] = 1'b0;

    for (genvar k = 0; k < spq_pkg::NUM_CLASSES; k++) begin : g_cell
        assign w_ctl[k].enq   = w_enq_ok && (r_cls == spq_pkg::CLS_W'(k));
        assign w_ctl[k].serve = w_exec && w_is_serve;

        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[k]),
            .i_claim (w_claim[k+1]),
            .o_claim (w_claim[k]),
            .o_sts   (w_sts[k])
        );
    end

    always_comb begin
        w_any_take = 1'b0;
        w_sel_cls  = '0;
        w_sel_head = '0;
        for (int k = 0; k < spq_pkg::NUM_CLASSES; k++) begin
            if (w_sts[k].take) begin
                w_any_take = 1'b1;
                w_sel_cls  = spq_pkg::CLS_W'(k);
                w_sel_head = w_sts[k].head;
            end
        end
    end

    // ---------------- tag store ----------------
    assign w_we    = w_enq_ok;
    assign w_waddr = {r_cls, w_target_tail};
    assign w_re    = w_exec && w_any_take;
    assign w_raddr = {w_sel_cls, w_sel_head};

    spq_ram #(
        .WIDTH (spq_pkg::TAG_W),
        .DEPTH (spq_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_tag),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- result ----------------
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_served_class <= 1'b0;
            r_served_level <= '0;
            if (w_is_enq) begin
                r_status <= w_target_full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQUEUED;
            end else if (w_is_serve && w_any_take) begin
                r_status       <= spq_pkg::ST_SERVED;
                r_served_class <= (w_sel_cls != '0);
                r_served_level <= spq_pkg::LVL_W'(w_sel_cls);
            end else begin
                r_status <= spq_pkg::ST_EMPTY;
            end
        end
    end

    assign o_res.status       = r_status;
    assign o_res.served_tag   = (r_status == spq_pkg::ST_SERVED) ? w_rdata : '0;
    assign o_res.served_class = r_served_class;
    assign o_res.served_level = r_served_level;

    // ---------------- assertions ----------------
    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not enter execute");

    a_exec_then_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_strobe && !busy))
        else $error("execute cycle not followed by a result beat");

    a_single_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_sts[3].take, w_sts[2].take, w_sts[1].take, w_sts[0].take}))
        else $error("more than one class served at once");

    a_plain_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.served_class) |-> (o_res.served_level == '0))
        else $error("level reported for a non-priority beat");

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for strict_priority_multi_queue_unit
// Drives command beats through the start/busy handshake and keeps a shadow
// scheduler with one plain class and one class per severity level. Every
// result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int MAX_PRINTED   = 30;

    logic            i_clk    = 1'b0;
    logic            i_rst_n  = 1'b0;
    logic            start    = 1'b0;
    spq_pkg::t_cmd   i_cmd    = '0;
    logic            busy;
    logic            o_strobe;
    spq_pkg::t_res   o_res;

    // shadow scheduler state
    logic [spq_pkg::TAG_W-1:0] shadow_tags [spq_pkg::NUM_CLASSES][spq_pkg::QUEUE_DEPTH];
    int               rd_ptr      [spq_pkg::NUM_CLASSES];
    int               wr_ptr      [spq_pkg::NUM_CLASSES];
    int               occupancy   [spq_pkg::NUM_CLASSES];

    spq_pkg::t_res pending_results[$];
    int   items_sent      = 0;
    int   results_checked = 0;
    int   mismatch_count  = 0;
    int   cycle_count     = 0;
    int   status_seen [4];
    int   level_served[4];

    strict_priority_multi_queue_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // shadow scheduler: one command in, one result out, state updated
    // ------------------------------------------------------------------------
    function automatic spq_pkg::t_res schedule_step(input spq_pkg::t_cmd cmd);
        spq_pkg::t_res r;
        int   cls;
        int   lvl;
        r        = '0;
        r.status = spq_pkg::ST_EMPTY;
        case (cmd.action)
            spq_pkg::ACT_ADD_PLAIN, spq_pkg::ACT_ADD_PRIO: begin
                if (cmd.action == spq_pkg::ACT_ADD_PLAIN) begin
                    cls = 0;
                end else if (cmd.severity_in == '0) begin
                    cls = 1;
                end else if (int'(cmd.severity_in) > spq_pkg::PRIO_LEVELS) begin
                    cls = spq_pkg::PRIO_LEVELS;
                end else begin
                    cls = int'(cmd.severity_in);
                end
                if (occupancy[cls] >= spq_pkg::QUEUE_DEPTH) begin
                    r.status = spq_pkg::ST_FULL;
                end else begin
                    shadow_tags[cls][wr_ptr[cls]] = cmd.tag_in;
                    wr_ptr[cls]    = (wr_ptr[cls] + 1) % spq_pkg::QUEUE_DEPTH;
                    occupancy[cls] = occupancy[cls] + 1;
                    r.status       = spq_pkg::ST_ENQUEUED;
                end
            end
            spq_pkg::ACT_SERVE: begin
                // highest non-empty severity first, plain class last
                cls = -1;
                for (lvl = spq_pkg::PRIO_LEVELS; lvl >= 0; lvl--) begin
                    if (cls < 0 && occupancy[lvl] != 0) cls = lvl;
                end
                if (cls >= 0) begin
                    r.status       = spq_pkg::ST_SERVED;
                    r.served_tag   = shadow_tags[cls][rd_ptr[cls]];
                    r.served_class = (cls != 0);
                    r.served_level = spq_pkg::LVL_W'(cls);
                    rd_ptr[cls]    = (rd_ptr[cls] + 1) % spq_pkg::QUEUE_DEPTH;
                    occupancy[cls] = occupancy[cls] - 1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h (cycle %0d)",
                     results_checked, what, got, want, cycle_count);
        end
    endtask

    // sampled mid-cycle; the beat is taken at the rising edge that follows
    always @(negedge i_clk) begin
        spq_pkg::t_res want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing pending", o_res, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch("status", o_res.status, want.status);
                if (o_res.served_tag !== want.served_tag)
                    report_mismatch("served_tag", o_res.served_tag, want.served_tag);
                if (o_res.served_class !== want.served_class)
                    report_mismatch("served_class", o_res.served_class,
                                    want.served_class);
                if (o_res.served_level !== want.served_level)
                    report_mismatch("served_level", o_res.served_level,
                                    want.served_level);
                status_seen[want.status]++;
                if (want.status == spq_pkg::ST_SERVED) level_served[want.served_level]++;
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    // start stays high from one beat to the next unless a gap is asked for
    task automatic send_cmd(input spq_pkg::t_action act,
                            input logic [spq_pkg::TAG_W-1:0] tag,
                            input logic [spq_pkg::SEV_W-1:0] sev, input int gap);
        spq_pkg::t_cmd cmd;
        cmd.action      = act;
        cmd.tag_in      = tag;
        cmd.severity_in = sev;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        // busy seen mid-cycle is what the next rising edge samples
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_results.push_back(schedule_step(cmd));
        items_sent++;
    endtask

    task automatic wait_drained(input int settle);
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [spq_pkg::SEV_W-1:0] sev_for_class(input int cls);
        case (cls)
            1:       return spq_pkg::SEV_W'($urandom_range(0, 1));
            2:       return spq_pkg::SEV_W'(2);
            default: return spq_pkg::SEV_W'($urandom_range(3, 7));
        endcase
    endfunction

    task automatic enqueue_to(input int cls, input bit no_idle);
        if (cls == 0) begin
            send_cmd(spq_pkg::ACT_ADD_PLAIN, spq_pkg::TAG_W'($urandom),
                     spq_pkg::SEV_W'($urandom), pick_gap(no_idle));
        end else begin
            send_cmd(spq_pkg::ACT_ADD_PRIO, spq_pkg::TAG_W'($urandom),
                     sev_for_class(cls), pick_gap(no_idle));
        end
    endtask

    task automatic serve_one(input bit no_idle);
        send_cmd(spq_pkg::ACT_SERVE, spq_pkg::TAG_W'($urandom),
                 spq_pkg::SEV_W'($urandom), pick_gap(no_idle));
    endtask

    task automatic send_mixed(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            send_cmd(spq_pkg::ACT_ADD_PLAIN, spq_pkg::TAG_W'($urandom),
                     spq_pkg::SEV_W'($urandom), pick_gap(no_idle));
        end else if (r < 65) begin
            send_cmd(spq_pkg::ACT_ADD_PRIO, spq_pkg::TAG_W'($urandom),
                     spq_pkg::SEV_W'($urandom), pick_gap(no_idle));
        end else if (r < 95) begin
            serve_one(no_idle);
        end else begin
            send_cmd(spq_pkg::ACT_NOP, spq_pkg::TAG_W'($urandom),
                     spq_pkg::SEV_W'($urandom), pick_gap(no_idle));
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_empty_and_nop();
        send_cmd(spq_pkg::ACT_SERVE, '0, '0, 0);
        send_cmd(spq_pkg::ACT_NOP, 16'hFFFF, 3'h7, 0);
        send_cmd(spq_pkg::ACT_SERVE, 16'hFFFF, 3'h7, 2);
    endtask

    task automatic test_tag_extremes();
        send_cmd(spq_pkg::ACT_ADD_PLAIN, 16'h0000, 3'h0, 0);
        send_cmd(spq_pkg::ACT_ADD_PLAIN, 16'hFFFF, 3'h7, 0);
        send_cmd(spq_pkg::ACT_ADD_PRIO, 16'hFFFF, 3'h7, 1);
        repeat (3) send_cmd(spq_pkg::ACT_SERVE, '0, '0, 0);
    endtask

    // every severity code, equal levels must come out in arrival order
    task automatic test_severity_order();
        int i;
        send_cmd(spq_pkg::ACT_ADD_PLAIN, 16'h5A5A, 3'h3, 0);
        for (i = 0; i < 8; i++) begin
            send_cmd(spq_pkg::ACT_ADD_PRIO, spq_pkg::TAG_W'(16'hA000 + i),
                     spq_pkg::SEV_W'(i), 0);
        end
        repeat (10) send_cmd(spq_pkg::ACT_SERVE, spq_pkg::TAG_W'($urandom),
                             spq_pkg::SEV_W'($urandom), 0);
    endtask

    // fill each class past full, then drain; second round wraps at an offset
    task automatic test_overflow_and_wrap();
        int round;
        int cls;
        for (round = 0; round < 2; round++) begin
            for (cls = 0; cls < spq_pkg::NUM_CLASSES; cls++) begin
                repeat (spq_pkg::QUEUE_DEPTH + $urandom_range(1, 3))
                    enqueue_to(cls, round == 0);
            end
            repeat (spq_pkg::NUM_CLASSES * spq_pkg::QUEUE_DEPTH + 2) serve_one(round == 0);
            for (cls = 0; cls < spq_pkg::NUM_CLASSES; cls++) begin
                repeat ($urandom_range(1, 7)) enqueue_to(cls, 1'b0);
            end
            repeat (spq_pkg::NUM_CLASSES * 7 + 1) serve_one(1'b0);
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int  goal;
        int  kind;
        int  len;
        int  cls;
        bit  no_idle;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            kind    = $urandom_range(0, 9);
            len     = $urandom_range(8, 40);
            no_idle = ($urandom_range(0, 4) == 0);
            case (kind)
                0, 1, 2, 3: repeat (len) send_mixed(no_idle);
                4, 5: begin
                    cls = $urandom_range(0, spq_pkg::NUM_CLASSES - 1);
                    repeat ($urandom_range(6, spq_pkg::QUEUE_DEPTH + 3))
                        enqueue_to(cls, no_idle);
                end
                6, 7: repeat (len) serve_one(no_idle);
                8: begin
                    for (cls = 0; cls < spq_pkg::NUM_CLASSES; cls++) begin
                        repeat (spq_pkg::QUEUE_DEPTH + 1) enqueue_to(cls, no_idle);
                    end
                end
                default: begin
                    if ($urandom_range(0, 2) == 0) wait_drained(0);
                    repeat (len) send_mixed(no_idle);
                end
            endcase
        end
    endtask

    initial begin
        for (int c = 0; c < spq_pkg::NUM_CLASSES; c++) begin
            rd_ptr[c]    = 0;
            wr_ptr[c]    = 0;
            occupancy[c] = 0;
        end
        for (int s = 0; s < 4; s++) begin
            status_seen[s]  = 0;
            level_served[s] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_nop();
        test_tag_extremes();
        test_severity_order();
        wait_drained(2);
        test_overflow_and_wrap();
        wait_drained(2);
        test_random_traffic(RANDOM_ITEMS);
        wait_drained(8);

        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);

        $display("Sent %0d commands: %0d enqueued, %0d served, %0d empty or no-op, %0d dropped full",
                 items_sent, status_seen[spq_pkg::ST_ENQUEUED],
                 status_seen[spq_pkg::ST_SERVED],
                 status_seen[spq_pkg::ST_EMPTY], status_seen[spq_pkg::ST_FULL]);
        $display("Served by class: plain %0d, level1 %0d, level2 %0d, level3 %0d; %0d mismatches",
                 level_served[0], level_served[1], level_served[2], level_served[3],
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[strict_priority_multi_queue_unit.f]
design/spq_pkg.sv
design/spq_ram.sv
design/spq_cell.sv
design/strict_priority_multi_queue_unit.sv
bench/testbench.sv
